### rtl/bgn_pkg.sv
package bgn_pkg;

	// ln 2 in Q0.32
	localparam logic [31:0] LN2_Q32 = 32'd2977044472;
	// top of the result range
	localparam logic [35:0] OUT_MAX = 36'hFFFFFFFFF;
	// exponent width, signed
	localparam int E_W = 12;
	// log2 fraction bits, one per cell
	localparam int LOG_N = 30;
	// width of x, signed
	localparam int X_W = 44;
	// radicand width and root width
	localparam int R_W = 2 * X_W;
	localparam int RT_W = X_W;

	typedef enum logic [1:0] {
		REG_REF_LOG   = 2'd0,
		REG_COEF      = 2'd1,
		REG_SMOOTH    = 2'd2,
		REG_OFFSET_EV = 2'd3
	} cfg_reg_t;

	// side data riding along the log chain
	typedef struct packed {
		logic signed [E_W-1:0] e;
		logic                  skip;
		logic                  inf;
	} log_carry_t;

	// side data riding along the root chain
	typedef struct packed {
		logic signed [X_W-1:0] x;
		logic                  skip;
		logic                  inf;
	} sqrt_carry_t;

endpackage

### rtl/bgn_log_cell.sv
module bgn_log_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_v,
	input  logic [30:0]         in_m,
	input  logic [29:0]         in_frac,
	input  bgn_pkg::log_carry_t in_c,
	output logic                out_v,
	output logic [30:0]         out_m,
	output logic [29:0]         out_frac,
	output bgn_pkg::log_carry_t out_c
);
	import bgn_pkg::*;

	logic [61:0] sq;
	logic [31:0] sq_top;
	logic        v_q;
	logic [30:0] m_q;
	logic [29:0] frac_q;
	log_carry_t  c_q;

	// square the significand, one log2 bit falls out
	assign sq = 62'(in_m) * 62'(in_m);
	assign sq_top = sq[61:30];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (en) begin
			v_q <= in_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_q <= sq_top[31] ? sq_top[31:1] : sq_top[30:0];
			frac_q <= {in_frac[28:0], sq_top[31]};
			c_q <= in_c;
		end
	end

	assign out_v = v_q;
	assign out_m = m_q;
	assign out_frac = frac_q;
	assign out_c = c_q;

endmodule

### rtl/bgn_sqrt_cell.sv
module bgn_sqrt_cell (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           en,
	input  logic                           in_v,
	input  logic [bgn_pkg::R_W-1:0]        in_rad,
	input  logic [bgn_pkg::RT_W+1:0]       in_rem,
	input  logic [bgn_pkg::RT_W-1:0]       in_root,
	input  bgn_pkg::sqrt_carry_t           in_c,
	output logic                           out_v,
	output logic [bgn_pkg::R_W-1:0]        out_rad,
	output logic [bgn_pkg::RT_W+1:0]       out_rem,
	output logic [bgn_pkg::RT_W-1:0]       out_root,
	output bgn_pkg::sqrt_carry_t           out_c
);
	import bgn_pkg::*;

	logic [RT_W+3:0] rem_sh;
	logic [RT_W+3:0] trial;
	logic [RT_W+3:0] rem_dif;
	logic            ge;
	logic            v_q;
	logic [R_W-1:0]  rad_q;
	logic [RT_W+1:0] rem_q;
	logic [RT_W-1:0] root_q;
	sqrt_carry_t     c_q;

	// bring down two radicand bits and try the next root bit
	assign rem_sh = {in_rem, in_rad[R_W-1 -: 2]};
	assign trial = {2'b00, in_root, 2'b01};
	assign ge = (rem_sh >= trial);
	assign rem_dif = rem_sh - trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (en) begin
			v_q <= in_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rad_q <= {in_rad[R_W-3:0], 2'b00};
			rem_q <= ge ? rem_dif[RT_W+1:0] : rem_sh[RT_W+1:0];
			root_q <= {in_root[RT_W-2:0], ge};
			c_q <= in_c;
		end
	end

	assign out_v = v_q;
	assign out_rad = rad_q;
	assign out_rem = rem_q;
	assign out_root = root_q;
	assign out_c = c_q;

endmodule

### rtl/bandgap_narrowing_smooth_log_core.sv
// channel  | signals                                   | item
// ---------+-------------------------------------------+-------------------------------
// input    | in_valid, in_ready                        | doping, electron, hole bits
// output   | out_valid, out_ready                      | narrowing, saturated
// config   | cfg_we, cfg_index, cfg_wdata              | one register write, no wait
// one item per cycle while the skid is empty; 87 register stages from input item to output register
// the stages include 30 squaring cells for log2 and 44 cells of the square root
// asynchronous reset clears all valid bits and loads register defaults
// output register plus one skid register: the pipe stops only when the skid is full
module bandgap_narrowing_smooth_log_core #(
	parameter int FRAC_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [63:0] doping_bits,
	input  logic [63:0] electrons_bits,
	input  logic [63:0] holes_bits,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [35:0] narrowing,
	output logic        saturated,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_wdata
);
	import bgn_pkg::*;

	localparam int SH = 32 - FRAC_BITS;
	localparam logic signed [45:0] LN_RND = 46'sd1 <<< (SH - 1);
	localparam logic [69:0] T_RND = 70'd1 << (FRAC_BITS - 1);

	// configuration registers
	logic signed [31:0] ref_log_q;
	logic [23:0]        coef_q;
	logic [23:0]        smooth_q;
	logic signed [31:0] offset_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_log_q <= 32'sd2565338;
			coef_q <= 24'd150995;
			smooth_q <= 24'd32768;
			offset_q <= 32'sd0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_REF_LOG:   ref_log_q <= cfg_wdata;
				REG_COEF:      coef_q <= cfg_wdata[23:0];
				REG_SMOOTH:    smooth_q <= cfg_wdata[23:0];
				REG_OFFSET_EV: offset_q <= cfg_wdata;
				default:       ;
			endcase
		end
	end

	// pipe advance, held only while the skid is full
	logic en;
	logic s_v_q;
	assign en = !s_v_q;
	assign in_ready = en;

	// candidate check and largest positive value; the sign bit of doping is ignored
	logic [62:0] c0, c1, c2;
	logic        p0, p1, p2;
	logic [62:0] b01;
	logic        a01;
	logic [62:0] best;
	logic        any;

	function automatic logic is_pos(input logic [63:0] b);
		logic nan;
		nan = (b[62:52] == 11'h7FF) && (b[51:0] != 52'd0);
		return !b[63] && !nan && (b[62:0] != 63'd0);
	endfunction

	assign c0 = doping_bits[62:0];
	assign c1 = electrons_bits[62:0];
	assign c2 = holes_bits[62:0];
	assign p0 = is_pos({1'b0, doping_bits[62:0]});
	assign p1 = is_pos(electrons_bits);
	assign p2 = is_pos(holes_bits);

	always_comb begin
		a01 = p0 || p1;
		b01 = c0;
		if (p1 && (!p0 || c1 > c0)) begin
			b01 = c1;
		end
		best = b01;
		if (p2 && (!a01 || c2 > b01)) begin
			best = c2;
		end
		any = a01 || p2;
	end

	logic        v_s1, skip_s1, inf_s1;
	logic [62:0] best_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			best_s1 <= best;
			skip_s1 <= !any || (coef_q == 24'd0);
			inf_s1 <= any && (best == 63'h7FF0000000000000);
		end
	end

	// exponent and leading zeros of the significand
	logic [52:0] sig;
	logic [5:0]  lz;
	logic signed [E_W-1:0] e_c;

	assign sig = {best_s1[62:52] != 11'd0, best_s1[51:0]};

	always_comb begin
		lz = 6'd0;
		for (int i = 0; i < 53; i++) begin
			if (sig[i]) begin
				lz = 6'(52 - i);
			end
		end
		if (best_s1[62:52] != 11'd0) begin
			e_c = $signed({1'b0, best_s1[62:52]}) - 12'sd1023;
		end else begin
			e_c = -12'sd1022 - $signed({6'd0, lz});
		end
	end

	logic        v_s2, skip_s2, inf_s2;
	logic [52:0] sig_s2;
	logic [5:0]  lz_s2;
	logic signed [E_W-1:0] e_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			sig_s2 <= sig;
			lz_s2 <= lz;
			e_s2 <= e_c;
			skip_s2 <= skip_s1;
			inf_s2 <= inf_s1;
		end
	end

	// normalise to a Q1.30 significand
	logic [52:0] norm;
	assign norm = sig_s2 << lz_s2;

	logic        v_s3;
	logic [30:0] m_s3;
	log_carry_t  lc_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			m_s3 <= norm[52:22];
			lc_s3 <= '{e: e_s2, skip: skip_s2, inf: inf_s2};
		end
	end

	// chain of squaring cells, one log2 fraction bit each
	logic       lg_v [LOG_N+1];
	logic [30:0] lg_m [LOG_N+1];
	logic [29:0] lg_f [LOG_N+1];
	log_carry_t lg_c [LOG_N+1];

	assign lg_v[0] = v_s3;
	assign lg_m[0] = m_s3;
	assign lg_f[0] = 30'd0;
	assign lg_c[0] = lc_s3;

	for (genvar g = 0; g < LOG_N; g++) begin : g_log
		bgn_log_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.in_v     (lg_v[g]),
			.in_m     (lg_m[g]),
			.in_frac  (lg_f[g]),
			.in_c     (lg_c[g]),
			.out_v    (lg_v[g+1]),
			.out_m    (lg_m[g+1]),
			.out_frac (lg_f[g+1]),
			.out_c    (lg_c[g+1])
		);
	end

	// scale exponent and fraction by ln 2
	logic        v_s4, skip_s4, inf_s4;
	logic signed [44:0] pe_s4;
	logic [61:0] pf_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			pe_s4 <= 45'(lg_c[LOG_N].e) * $signed({13'd0, LN2_Q32});
			pf_s4 <= 62'(lg_f[LOG_N]) * 62'(LN2_Q32);
			skip_s4 <= lg_c[LOG_N].skip;
			inf_s4 <= lg_c[LOG_N].inf;
		end
	end

	// ln in Q32, rounded half up to the output fraction
	logic signed [45:0] lnq;
	logic signed [45:0] lnr;
	logic signed [45:0] ln_sh;

	assign lnq = $signed({pe_s4[44], pe_s4}) + $signed({14'd0, pf_s4[61:30]});
	assign lnr = lnq + LN_RND;
	assign ln_sh = lnr >>> SH;

	logic        v_s5, skip_s5, inf_s5;
	logic signed [X_W-1:0] ln_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			ln_s5 <= ln_sh[X_W-1:0];
			skip_s5 <= skip_s4;
			inf_s5 <= inf_s4;
		end
	end

	// subtract the reference level
	logic        v_s6, skip_s6, inf_s6;
	logic signed [X_W-1:0] x_s6;

	always_ff @(posedge clk) begin
		if (en) begin
			x_s6 <= ln_s5 - X_W'(ref_log_q);
			skip_s6 <= skip_s5;
			inf_s6 <= inf_s5;
		end
	end

	// partial products of x squared
	logic [X_W-1:0] ux;
	assign ux = x_s6[X_W-1] ? X_W'(-x_s6) : X_W'(x_s6);

	logic        v_s7, skip_s7, inf_s7;
	logic signed [X_W-1:0] x_s7;
	logic [X_W-1:0] aa_s7, ab_s7, bb_s7;

	always_ff @(posedge clk) begin
		if (en) begin
			aa_s7 <= X_W'(ux[X_W-1:X_W/2]) * X_W'(ux[X_W-1:X_W/2]);
			ab_s7 <= X_W'(ux[X_W-1:X_W/2]) * X_W'(ux[X_W/2-1:0]);
			bb_s7 <= X_W'(ux[X_W/2-1:0]) * X_W'(ux[X_W/2-1:0]);
			x_s7 <= x_s6;
			skip_s7 <= skip_s6;
			inf_s7 <= inf_s6;
		end
	end

	// radicand x*x + smooth
	logic        v_s8;
	logic [R_W-1:0] rad_s8;
	sqrt_carry_t sc_s8;

	always_ff @(posedge clk) begin
		if (en) begin
			rad_s8 <= {aa_s7, X_W'(0)} + (R_W'(ab_s7) << (X_W/2 + 1)) + R_W'(bb_s7)
				+ (R_W'(smooth_q) << FRAC_BITS);
			sc_s8 <= '{x: x_s7, skip: skip_s7, inf: inf_s7};
		end
	end

	// chain of root cells, one root bit each
	logic            sq_v [RT_W+1];
	logic [R_W-1:0]  sq_rad [RT_W+1];
	logic [RT_W+1:0] sq_rem [RT_W+1];
	logic [RT_W-1:0] sq_root [RT_W+1];
	sqrt_carry_t     sq_c [RT_W+1];

	assign sq_v[0] = v_s8;
	assign sq_rad[0] = rad_s8;
	assign sq_rem[0] = '0;
	assign sq_root[0] = '0;
	assign sq_c[0] = sc_s8;

	for (genvar g = 0; g < RT_W; g++) begin : g_sqrt
		bgn_sqrt_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.in_v     (sq_v[g]),
			.in_rad   (sq_rad[g]),
			.in_rem   (sq_rem[g]),
			.in_root  (sq_root[g]),
			.in_c     (sq_c[g]),
			.out_v    (sq_v[g+1]),
			.out_rad  (sq_rad[g+1]),
			.out_rem  (sq_rem[g+1]),
			.out_root (sq_root[g+1]),
			.out_c    (sq_c[g+1])
		);
	end

	// x plus root, never negative
	logic signed [X_W+1:0] t_sum;
	assign t_sum = (X_W+2)'(sq_c[RT_W].x) + $signed({2'b00, sq_root[RT_W]});

	logic        v_s9, skip_s9, inf_s9;
	logic [X_W:0] t_s9;

	always_ff @(posedge clk) begin
		if (en) begin
			t_s9 <= t_sum[X_W:0];
			skip_s9 <= sq_c[RT_W].skip;
			inf_s9 <= sq_c[RT_W].inf;
		end
	end

	// coefficient times t in two halves
	logic        v_s10, skip_s10, inf_s10;
	logic [45:0] ph_s10;
	logic [46:0] pl_s10;

	always_ff @(posedge clk) begin
		if (en) begin
			ph_s10 <= 46'(coef_q) * 46'(t_s9[X_W:23]);
			pl_s10 <= 47'(coef_q) * 47'(t_s9[22:0]);
			skip_s10 <= skip_s9;
			inf_s10 <= inf_s9;
		end
	end

	// join halves and round half up
	logic [69:0] tsum;
	assign tsum = {1'b0, ph_s10, 23'd0} + 70'(pl_s10) + T_RND;

	logic        v_s11, skip_s11, inf_s11;
	logic [69:0] term_s11;

	always_ff @(posedge clk) begin
		if (en) begin
			term_s11 <= tsum >> FRAC_BITS;
			skip_s11 <= skip_s10;
			inf_s11 <= inf_s10;
		end
	end

	// add offset, clamp at zero and saturate at the top
	logic signed [70:0] delta;
	logic [35:0] res_n;
	logic        res_s;

	assign delta = $signed({1'b0, term_s11}) + 71'(offset_q);

	always_comb begin
		res_n = 36'd0;
		res_s = 1'b0;
		if (skip_s11) begin
			res_n = 36'd0;
		end else if (inf_s11) begin
			res_n = OUT_MAX;
			res_s = 1'b1;
		end else if (delta[70]) begin
			res_n = 36'd0;
		end else if (delta[69:36] != 34'd0) begin
			res_n = OUT_MAX;
			res_s = 1'b1;
		end else begin
			res_n = delta[35:0];
		end
	end

	logic        v_s12;
	logic [35:0] narrow_s12;
	logic        sat_s12;

	always_ff @(posedge clk) begin
		if (en) begin
			narrow_s12 <= res_n;
			sat_s12 <= res_s;
		end
	end

	// valid bits of the front and back stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			v_s9 <= 1'b0;
			v_s10 <= 1'b0;
			v_s11 <= 1'b0;
			v_s12 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= lg_v[LOG_N];
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
			v_s9 <= sq_v[RT_W];
			v_s10 <= v_s9;
			v_s11 <= v_s10;
			v_s12 <= v_s11;
		end
	end

	// output register and skid
	logic        o_v_q;
	logic [35:0] o_narrow_q, s_narrow_q;
	logic        o_sat_q, s_sat_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			o_v_q <= 1'b0;
			s_v_q <= 1'b0;
		end else if (out_ready || !o_v_q) begin
			if (s_v_q) begin
				o_v_q <= 1'b1;
				s_v_q <= 1'b0;
			end else begin
				o_v_q <= v_s12;
			end
		end else if (v_s12 && en) begin
			s_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_ready || !o_v_q) begin
			if (s_v_q) begin
				o_narrow_q <= s_narrow_q;
				o_sat_q <= s_sat_q;
			end else begin
				o_narrow_q <= narrow_s12;
				o_sat_q <= sat_s12;
			end
		end else if (v_s12 && en) begin
			s_narrow_q <= narrow_s12;
			s_sat_q <= sat_s12;
		end
	end

	assign out_valid = o_v_q;
	assign narrowing = o_narrow_q;
	assign saturated = o_sat_q;

	// skid holds an item only behind a full output register
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		s_v_q |-> o_v_q) else $error("skid full with empty output");

	// skid fills only when the output was stalled
	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(s_v_q) |-> $past(o_v_q && !out_ready)) else $error("skid filled without stall");

	// flag only at the top of the range
	a_sat_top: assert property (@(posedge clk) disable iff (!arst_n)
		(o_v_q && o_sat_q) |-> (o_narrow_q == OUT_MAX)) else $error("flag without top value");

	// squaring keeps the significand in [1,2)
	a_log_norm: assert property (@(posedge clk) disable iff (!arst_n)
		(lg_v[LOG_N] && !lg_c[LOG_N].skip && !lg_c[LOG_N].inf) |-> lg_m[LOG_N][30])
		else $error("log significand lost its leading one");

	// root remainder never exceeds twice the root
	a_root_rem: assert property (@(posedge clk) disable iff (!arst_n)
		sq_v[RT_W] |-> (sq_rem[RT_W] <= {1'b0, sq_root[RT_W], 1'b0}))
		else $error("root remainder too large");

endmodule
